[hw/rtl/cdu_pkg.sv]
// Shared types, constants and calendar tables of the calendar date unit.
`timescale 1ns / 1ps

package cdu_pkg;

  typedef logic [4:0]  day_t;
  typedef logic [3:0]  month_t;
  typedef logic [13:0] year_t;
  typedef logic [2:0]  wday_t;
  typedef logic [8:0]  ord_t;
  typedef logic [7:0]  cent_t;

  localparam year_t  YearMin      = 14'd1;
  localparam year_t  YearMax      = 14'd9999;
  localparam month_t MonthJan     = 4'd1;
  localparam month_t MonthFeb     = 4'd2;
  localparam month_t MonthDec     = 4'd12;
  localparam day_t   DayFirst     = 5'd1;
  localparam day_t   DayDecLast   = 5'd31;
  localparam wday_t  WdayFri      = 3'd5;
  localparam wday_t  WdaySat      = 3'd6;
  localparam logic [3:0] WeekLen  = 4'd7;

  // floor(y / 100) = (y * Recip100) >> Recip100Shift for every 14-bit y
  localparam int unsigned ProdW        = 27;
  localparam logic [12:0] Recip100     = 13'd5243;
  localparam int unsigned Recip100Shift = 19;
  localparam logic [6:0]  Hundred      = 7'd100;

  typedef struct packed {
    day_t   day;
    month_t month;
    year_t  year;
  } date_t;

  typedef struct packed {
    logic load;
    logic valid;
  } pipe_ctl_t;

  typedef struct packed {
    day_t   day;
    month_t month;
    year_t  year;
    logic   leap;
    logic   ok;
    day_t   len;
    year_t  yy;
    cent_t  cent;
  } mid_t;

  typedef struct packed {
    logic   leap;
    logic   valid_res;
    day_t   month_length;
    wday_t  weekday;
    ord_t   ordinal_day;
    logic   weekend;
    day_t   next_day;
    month_t next_month;
    year_t  next_year;
    day_t   prev_day;
    month_t prev_month;
    year_t  prev_year;
  } res_t;

  function automatic day_t month_len(month_t m, logic leap);
    day_t len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
      4'd2:                                        len = leap ? 5'd29 : 5'd28;
      default:                                     len = 5'd0;
    endcase
    return len;
  endfunction

  // (31 * shifted month) / 12, March as month one
  function automatic day_t month_offset(month_t m);
    day_t ofs;
    unique case (m)
      4'd1:    ofs = 5'd28;
      4'd2:    ofs = 5'd31;
      4'd3:    ofs = 5'd2;
      4'd4:    ofs = 5'd5;
      4'd5:    ofs = 5'd7;
      4'd6:    ofs = 5'd10;
      4'd7:    ofs = 5'd12;
      4'd8:    ofs = 5'd15;
      4'd9:    ofs = 5'd18;
      4'd10:   ofs = 5'd20;
      4'd11:   ofs = 5'd23;
      4'd12:   ofs = 5'd25;
      default: ofs = 5'd0;
    endcase
    return ofs;
  endfunction

  // days before the first of the month in a common year
  function automatic ord_t days_before(month_t m);
    ord_t n;
    unique case (m)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

[hw/rtl/cdu_req_if.sv]
// Request channel of the calendar date unit: one date per request.
`timescale 1ns / 1ps

interface cdu_req_if;
  logic            valid;
  logic            ready;
  cdu_pkg::day_t   day;
  cdu_pkg::month_t month;
  cdu_pkg::year_t  year;

  modport source (output valid, output day, output month, output year, input ready);
  modport sink   (input valid, input day, input month, input year, output ready);
endinterface

[hw/rtl/cdu_res_if.sv]
// Result channel of the calendar date unit: one result per request.
`timescale 1ns / 1ps

interface cdu_res_if;
  logic            valid;
  logic            ready;
  logic            leap;
  logic            valid_res;
  cdu_pkg::day_t   month_length;
  cdu_pkg::wday_t  weekday;
  cdu_pkg::ord_t   ordinal_day;
  logic            weekend;
  cdu_pkg::day_t   next_day;
  cdu_pkg::month_t next_month;
  cdu_pkg::year_t  next_year;
  cdu_pkg::day_t   prev_day;
  cdu_pkg::month_t prev_month;
  cdu_pkg::year_t  prev_year;

  modport source (
    output valid, output leap, output valid_res, output month_length, output weekday,
    output ordinal_day, output weekend, output next_day, output next_month,
    output next_year, output prev_day, output prev_month, output prev_year,
    input ready
  );
  modport sink (
    input valid, input leap, input valid_res, input month_length, input weekday,
    input ordinal_day, input weekend, input next_day, input next_month,
    input next_year, input prev_day, input prev_month, input prev_year,
    output ready
  );
endinterface

[hw/rtl/cdu_year_stage.sv]
// Year stage: century split, leap flag, month length and date check.
`timescale 1ns / 1ps

module cdu_year_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cdu_pkg::pipe_ctl_t  ctl_i,
  input  cdu_pkg::date_t      date_i,
  output logic                valid_o,
  output cdu_pkg::mid_t       mid_o
);

  logic [cdu_pkg::ProdW-1:0] prod;
  cdu_pkg::cent_t            q100;
  cdu_pkg::year_t            r100;
  logic                      cent_even;
  logic                      early;
  logic                      leap;
  cdu_pkg::day_t             len;
  cdu_pkg::mid_t             mid_d, mid_q;
  logic                      valid_d, valid_q;

  always_comb begin
    prod      = cdu_pkg::ProdW'(date_i.year) * cdu_pkg::ProdW'(cdu_pkg::Recip100);
    q100      = prod[cdu_pkg::Recip100Shift +: 8];
    r100      = date_i.year - (14'(q100) * 14'(cdu_pkg::Hundred));
    cent_even = (r100 == 14'd0);
    leap      = ((date_i.year[1:0] == 2'd0) && !cent_even) ||
                (cent_even && (q100[1:0] == 2'd0));
    len       = cdu_pkg::month_len(date_i.month, leap);
    early     = (date_i.month == cdu_pkg::MonthJan) || (date_i.month == cdu_pkg::MonthFeb);

    mid_d.day   = date_i.day;
    mid_d.month = date_i.month;
    mid_d.year  = date_i.year;
    mid_d.leap  = leap;
    mid_d.len   = len;
    mid_d.ok    = (len != 5'd0) && (date_i.day != 5'd0) && (date_i.day <= len) &&
                  (date_i.year >= cdu_pkg::YearMin) && (date_i.year <= cdu_pkg::YearMax);
    // January and February count toward the previous year
    mid_d.yy    = early ? date_i.year - 14'd1 : date_i.year;
    mid_d.cent  = (early && cent_even) ? q100 - 8'd1 : q100;

    valid_d = ctl_i.load ? ctl_i.valid : valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      mid_q <= mid_d;
    end
  end

  assign valid_o = valid_q;
  assign mid_o   = mid_q;

endmodule

[hw/rtl/cdu_date_stage.sv]
// Date stage: weekday, day of year, next and previous dates, result register.
`timescale 1ns / 1ps

module cdu_date_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cdu_pkg::pipe_ctl_t  ctl_i,
  input  cdu_pkg::mid_t       mid_i,
  output logic                valid_o,
  output cdu_pkg::res_t       res_o
);

  logic [14:0]     sum;
  logic [5:0]      fold1;
  logic [3:0]      fold2;
  cdu_pkg::wday_t  wday;
  cdu_pkg::month_t pm;
  cdu_pkg::res_t   res_d, res_q;
  logic            valid_d, valid_q;

  always_comb begin
    sum = 15'(mid_i.day) + 15'(mid_i.yy) + 15'(mid_i.yy >> 2) - 15'(mid_i.cent) +
          15'(mid_i.cent >> 2) + 15'(cdu_pkg::month_offset(mid_i.month));
    // fold octal digits: 8 is 1 modulo 7
    fold1 = 6'(sum[2:0]) + 6'(sum[5:3]) + 6'(sum[8:6]) + 6'(sum[11:9]) + 6'(sum[14:12]);
    fold2 = 4'(fold1[2:0]) + 4'(fold1[5:3]);
    wday  = (fold2 >= cdu_pkg::WeekLen) ? 3'(fold2 - cdu_pkg::WeekLen) : fold2[2:0];
    pm    = mid_i.month - 4'd1;

    res_d              = '0;
    res_d.leap         = mid_i.leap;
    res_d.valid_res    = mid_i.ok;
    res_d.month_length = mid_i.len;

    if (mid_i.ok) begin
      res_d.weekday     = wday;
      res_d.weekend     = (wday == cdu_pkg::WdayFri) || (wday == cdu_pkg::WdaySat);
      res_d.ordinal_day = cdu_pkg::days_before(mid_i.month) + 9'(mid_i.day) +
                          9'(mid_i.leap && (mid_i.month > cdu_pkg::MonthFeb));

      res_d.next_day   = mid_i.day + 5'd1;
      res_d.next_month = mid_i.month;
      res_d.next_year  = mid_i.year;
      if (mid_i.day == mid_i.len) begin
        res_d.next_day = cdu_pkg::DayFirst;
        if (mid_i.month != cdu_pkg::MonthDec) begin
          res_d.next_month = mid_i.month + 4'd1;
        end else if (mid_i.year == cdu_pkg::YearMax) begin
          res_d.next_day = mid_i.day;
        end else begin
          res_d.next_month = cdu_pkg::MonthJan;
          res_d.next_year  = mid_i.year + 14'd1;
        end
      end

      res_d.prev_day   = mid_i.day - 5'd1;
      res_d.prev_month = mid_i.month;
      res_d.prev_year  = mid_i.year;
      if (mid_i.day == cdu_pkg::DayFirst) begin
        if (mid_i.month != cdu_pkg::MonthJan) begin
          res_d.prev_month = pm;
          res_d.prev_day   = cdu_pkg::month_len(pm, mid_i.leap);
        end else if (mid_i.year == cdu_pkg::YearMin) begin
          res_d.prev_day = mid_i.day;
        end else begin
          res_d.prev_day   = cdu_pkg::DayDecLast;
          res_d.prev_month = cdu_pkg::MonthDec;
          res_d.prev_year  = mid_i.year - 14'd1;
        end
      end
    end

    valid_d = ctl_i.load ? ctl_i.valid : valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

[hw/rtl/calendar_date_unit.sv]
// Top level of the calendar date unit: request register, two stages, result channel.
//
// Usage:
//   req_i carries one Gregorian date (day, month, year) per request; res_o returns
//   one result per request, in order: leap flag, validity, month length, weekday
//   (0 Sunday), day of year, weekend flag (Friday or Saturday), next and previous
//   dates. Fields other than leap, valid_res and month_length read zero for a
//   date that is not real.
// Path: a request accepted on req_i passes the request register, the year stage
//   register and the result register in that order; a stall on res_o can hold it.
// Throughput: one request per cycle, sustained while res_o.ready is high; the three
//   pipeline registers each take a new entry in every cycle that the result is taken.
// Stall: when res_o.ready is low the result holds; the stages behind it keep
//   filling until all three registers are full, then req_i.ready drops.
// Reset: rst_ni clears the pipeline valid flags; no request is in flight and
//   req_i.ready is high once reset is released.
`timescale 1ns / 1ps

module calendar_date_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  cdu_req_if.sink    req_i,
  cdu_res_if.source  res_o
);

  cdu_pkg::date_t     req_d, req_q;
  logic               req_v_d, req_v_q;
  logic               in_take, mid_take, out_take;
  logic               mid_valid, res_valid;
  cdu_pkg::pipe_ctl_t ctl_a, ctl_b;
  cdu_pkg::mid_t      mid;
  cdu_pkg::res_t      res;

  always_comb begin
    out_take = !res_valid || res_o.ready;
    mid_take = !mid_valid || out_take;
    in_take  = !req_v_q || mid_take;

    ctl_a.load  = mid_take;
    ctl_a.valid = req_v_q;
    ctl_b.load  = out_take;
    ctl_b.valid = mid_valid;

    req_d.day   = req_i.day;
    req_d.month = req_i.month;
    req_d.year  = req_i.year;
    req_v_d     = in_take ? req_i.valid : req_v_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_v_q <= 1'b0;
    end else begin
      req_v_q <= req_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      req_q <= req_d;
    end
  end

  cdu_year_stage u_year (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_a),
    .date_i  (req_q),
    .valid_o (mid_valid),
    .mid_o   (mid)
  );

  cdu_date_stage u_date (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_b),
    .mid_i   (mid),
    .valid_o (res_valid),
    .res_o   (res)
  );

  assign req_i.ready        = in_take;
  assign res_o.valid        = res_valid;
  assign res_o.leap         = res.leap;
  assign res_o.valid_res    = res.valid_res;
  assign res_o.month_length = res.month_length;
  assign res_o.weekday      = res.weekday;
  assign res_o.ordinal_day  = res.ordinal_day;
  assign res_o.weekend      = res.weekend;
  assign res_o.next_day     = res.next_day;
  assign res_o.next_month   = res.next_month;
  assign res_o.next_year    = res.next_year;
  assign res_o.prev_day     = res.prev_day;
  assign res_o.prev_month   = res.prev_month;
  assign res_o.prev_year    = res.prev_year;

endmodule
